### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, off while reset is high.
`define RMF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rmf assertion failed");

// Concurrent check on a clock that also holds through reset.
`define RMF_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rmf assertion failed");

`endif

### rtl/rmf_pkg.sv
`timescale 1ns / 1ps

package rmf_pkg;

   // channel and field widths
   localparam int CHAN_W   = 8;
   localparam int FW_W     = 12;
   localparam int FH_W     = 13;
   localparam int ROW_W    = 14;
   localparam int CSR_W    = 13;
   localparam int WIN_SIZE = 9;
   localparam int MED_RANK = 4;

   // register reset values
   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

   // register indexes
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // request actions
   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   typedef struct packed {
      logic              action;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              frame_last;
   } rsp_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pix_type;

   // one line memory entry: previous row and the row before it
   typedef struct packed {
      pix_type prev1;
      pix_type prev2;
   } line_type;

   localparam int LINE_W = $bits(line_type);

   // control of the request held in the window stage
   typedef struct packed {
      logic col0;
      logic row_ge1;
      logic row_ge2;
      logic drain;
      logic emit;
   } ctl_type;

endpackage

### rtl/rmf_median.sv
`timescale 1ns / 1ps

module rmf_median
   import rmf_pkg::*;
(
   input  logic [WIN_SIZE-1:0][CHAN_W-1:0] vals,
   output logic [CHAN_W-1:0]               med
);

   logic [3:0] below  [WIN_SIZE];
   logic [3:0] at_or_below [WIN_SIZE];

   // rank of every sample against all others
   always_comb begin
      for (int i = 0; i < WIN_SIZE; i++) begin
         below[i]       = 4'd0;
         at_or_below[i] = 4'd0;
         for (int j = 0; j < WIN_SIZE; j++) begin
            below[i]       = below[i] + 4'(vals[j] < vals[i]);
            at_or_below[i] = at_or_below[i] + 4'(vals[j] <= vals[i]);
         end
      end
   end

   // first sample whose rank range covers the middle
   always_comb begin
      logic found;
      found = 1'b0;
      med   = '0;
      for (int i = 0; i < WIN_SIZE; i++) begin
         if (!found && below[i] <= 4'(MED_RANK) && at_or_below[i] >= 4'(MED_RANK + 1)) begin
            med   = vals[i];
            found = 1'b1;
         end
      end
   end

endmodule

### rtl/rmf_line_mem.sv
`timescale 1ns / 1ps

module rmf_line_mem
   import rmf_pkg::*;
#(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
)
(
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output line_type      rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  line_type      wr_data
);

   line_type mem [DEPTH];
   line_type rd_data_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rgb_median_filter_3x3_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Signals
// req       in         req_valid, req_stall, req_data (action, red/green/blue in)
// rsp       out        rsp_valid, rsp_stall, rsp_data (red/green/blue out, frame_last)
// csr       in         csr_we, csr_index, csr_wdata
//
// One request per clock while req_stall is low; a result is held in the result register.
// The path is the line memory read register, then the window and median network.
// Synchronous reset clears control only; the line memory needs no clearing pass.
// req_stall rises only while a result waits under rsp_stall and the next one is ready.

module rgb_median_filter_3x3_unit
   import rmf_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

   logic [FW_W-1:0]  width_ff;
   logic [FH_W-1:0]  height_ff;
   logic [CW-1:0]    col_ff;
   logic [ROW_W-1:0] row_ff;

   logic [EW-1:0]    fw_ext;
   logic [EW-1:0]    eff_w;
   logic [CW-1:0]    last_col;
   logic [FH_W-1:0]  eff_h;
   logic [ROW_W-1:0] h_ext;

   logic             accept;
   logic             is_flush;
   logic             row_lt_h;
   logic             take;
   logic             drain;
   logic             col_step;
   ctl_type          ctl_in;
   pix_type          bot_in;

   logic             valid1_ff;
   logic             valid1_in;
   ctl_type          ctl1_ff;
   pix_type          bot1_ff;
   logic [CW-1:0]    addr1_ff;
   logic             adv1;

   line_type         rd_line;
   line_type         wr_line;
   pix_type          top;
   pix_type          mid;
   pix_type          bot;

   pix_type [WIN_SIZE-1:0] win_ff;
   pix_type [WIN_SIZE-1:0] win_in;
   pix_type [WIN_SIZE-1:0] emit_win;

   logic [WIN_SIZE-1:0][CHAN_W-1:0] red_vals;
   logic [WIN_SIZE-1:0][CHAN_W-1:0] green_vals;
   logic [WIN_SIZE-1:0][CHAN_W-1:0] blue_vals;
   logic [CHAN_W-1:0] red_med;
   logic [CHAN_W-1:0] green_med;
   logic [CHAN_W-1:0] blue_med;

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;

   // effective frame size
   always_comb begin
      fw_ext = EW'(width_ff);
      if (fw_ext < EW'(2)) begin
         eff_w = EW'(2);
      end else if (fw_ext > EW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = fw_ext;
      end
      last_col = CW'(eff_w - EW'(1));
      eff_h    = (height_ff < FH_W'(2)) ? FH_W'(2) : height_ff;
      h_ext    = ROW_W'(eff_h);
   end

   // request decode
   assign accept   = req_valid && !req_stall;
   assign is_flush = (req_data.action == ACTION_FLUSH);
   assign row_lt_h = (row_ff < h_ext);
   assign take     = accept && (row_lt_h ? !is_flush : is_flush);
   assign drain    = take && (row_ff > h_ext);
   assign col_step = take && !drain;

   always_comb begin
      ctl_in.col0    = (col_ff == '0);
      ctl_in.row_ge1 = (row_ff != '0);
      ctl_in.row_ge2 = (row_ff >= ROW_W'(2));
      ctl_in.drain   = drain;
      ctl_in.emit    = drain || (ctl_in.col0 ? ctl_in.row_ge2 : ctl_in.row_ge1);
      if (row_lt_h) begin
         bot_in = '{red: req_data.red_in, green: req_data.green_in, blue: req_data.blue_in};
      end else begin
         bot_in = '0;
      end
   end

   // registers and input position
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RST;
         height_ff <= FRAME_HEIGHT_RST;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[FW_W-1:0];
            CSR_FRAME_HEIGHT: height_ff <= csr_wdata[FH_W-1:0];
         endcase
         col_ff <= '0;
         row_ff <= '0;
      end else if (take) begin
         if (drain) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (col_ff == last_col) begin
            col_ff <= '0;
            row_ff <= row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   // line memory: read when a non-drain request is taken, written back when the window stage moves on
   rmf_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (col_step),
      .rd_addr (col_ff),
      .rd_data (rd_line),
      .wr_en   (adv1 && !ctl1_ff.drain),
      .wr_addr (addr1_ff),
      .wr_data (wr_line)
   );

   // window stage handshake
   assign adv1      = valid1_ff && (!ctl1_ff.emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall = valid1_ff && !adv1;
   assign valid1_in = take ? 1'b1 : (adv1 ? 1'b0 : valid1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
      end
      if (take) begin
         ctl1_ff  <= ctl_in;
         bot1_ff  <= bot_in;
         addr1_ff <= col_ff;
      end
   end

   // new column, masked above the frame
   always_comb begin
      top = ctl1_ff.row_ge2 ? rd_line.prev2 : '0;
      mid = ctl1_ff.row_ge1 ? rd_line.prev1 : '0;
      bot = bot1_ff;
      wr_line = '{prev1: bot, prev2: mid};
   end

   // window seen by the median and window kept for the next column
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         emit_win[k] = win_ff[k + 3];
      end
      if (ctl1_ff.col0 || ctl1_ff.drain) begin
         emit_win[6] = '0;
         emit_win[7] = '0;
         emit_win[8] = '0;
      end else begin
         emit_win[6] = top;
         emit_win[7] = mid;
         emit_win[8] = bot;
      end
      if (ctl1_ff.col0) begin
         win_in    = '0;
         win_in[6] = top;
         win_in[7] = mid;
         win_in[8] = bot;
      end else begin
         win_in = emit_win;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         win_ff <= win_in;
      end
   end

   // per-channel medians
   always_comb begin
      for (int k = 0; k < WIN_SIZE; k++) begin
         red_vals[k]   = emit_win[k].red;
         green_vals[k] = emit_win[k].green;
         blue_vals[k]  = emit_win[k].blue;
      end
   end

   rmf_median u_med_red   (.vals(red_vals),   .med(red_med));
   rmf_median u_med_green (.vals(green_vals), .med(green_med));
   rmf_median u_med_blue  (.vals(blue_vals),  .med(blue_med));

   // result register
   assign rsp_valid_in = (adv1 && ctl1_ff.emit) ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (adv1 && ctl1_ff.emit) begin
         rsp_data_ff <= '{red_out: red_med, green_out: green_med, blue_out: blue_med,
                          frame_last: ctl1_ff.drain};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/rmf_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rmf_checker
   import rmf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // no result comes out of reset
   `RMF_ASSERT_NR(a_no_rsp_after_reset, clock, reset |=> !rsp_valid)

   // requests back up only behind a blocked result
   `RMF_ASSERT(a_stall_cause, clock, reset, (req_valid && req_stall) |-> (rsp_valid && rsp_stall))

   // a blocked result holds
   `RMF_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))

   // the next frame cannot produce a result right after the last one
   `RMF_ASSERT(a_gap_after_last, clock, reset, (rsp_valid && !rsp_stall && rsp_data.frame_last) |=> !rsp_valid)

endmodule

bind rgb_median_filter_3x3_unit rmf_checker u_rmf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import rmf_pkg::*;

   localparam int MAX_W = 2048;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we    = 1'b0;
   logic             csr_index = 1'b0;
   logic [CSR_W-1:0] csr_wdata = '0;

   // share of requests followed by a gap, and of cycles that start an output stall
   int unsigned idle_pct   = 10;
   int unsigned mismatches = 0;

   // filter state as seen from outside
   logic [FW_W-1:0] cfg_width;
   logic [FH_W-1:0] cfg_height;
   logic [23:0]     line_a [MAX_W];   // previous row
   logic [23:0]     line_b [MAX_W];   // row before that
   logic [23:0]     win [9];          // column * 3 + row, column 0 is the left one
   int unsigned     in_col, in_row, out_col, out_row;

   rsp_type expected_medians [$];

   rgb_median_filter_3x3_unit #(.MAX_WIDTH(MAX_W)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // median predictor
   // ------------------------------------------------------------------

   function automatic logic [7:0] chan_median(int unsigned sh);
      logic [7:0] v [9];
      logic [7:0] t;
      int i, j;
      for (i = 0; i < 9; i++) v[i] = win[i][sh +: 8];
      for (i = 1; i < 9; i++) begin
         for (j = i; j > 0 && v[j-1] > v[j]; j--) begin
            t = v[j];
            v[j] = v[j-1];
            v[j-1] = t;
         end
      end
      return v[4];
   endfunction

   function automatic void shift_column(logic [23:0] top, logic [23:0] mid, logic [23:0] bot);
      int k;
      for (k = 0; k < 6; k++) win[k] = win[k+3];
      win[6] = top;
      win[7] = mid;
      win[8] = bot;
   endfunction

   function automatic void clear_positions();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   // median of the current window, then advance the output position
   function automatic rsp_type next_median_pixel(int unsigned w, int unsigned h);
      rsp_type px;
      px.red_out    = chan_median(16);
      px.green_out  = chan_median(8);
      px.blue_out   = chan_median(0);
      px.frame_last = (out_row == h - 1) && (out_col == w - 1);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      return px;
   endfunction

   // one accepted request; returns 1 when it produces a filtered pixel
   function automatic bit median_step(input req_type rq, output rsp_type res);
      int unsigned w, h, c, r, k;
      logic [23:0] top, mid, bot;
      bit got;
      w = (cfg_width < 2) ? 2 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
      h = (cfg_height < 2) ? 2 : cfg_height;
      c = in_col;
      r = in_row;
      got = 1'b0;
      res = '0;

      // pixels only inside the frame, flushes only after it
      if (r < h) begin
         if (rq.action == ACTION_FLUSH) return 1'b0;
         bot = {rq.red_in, rq.green_in, rq.blue_in};
      end else begin
         if (rq.action == ACTION_PIXEL) return 1'b0;
         bot = '0;
      end

      // final flush: last pixel of the last row
      if (r > h) begin
         shift_column('0, '0, '0);
         res = next_median_pixel(w, h);
         clear_positions();
         return 1'b1;
      end

      c = c % MAX_W;
      top = (r >= 2) ? line_b[c] : '0;
      mid = (r >= 1) ? line_a[c] : '0;
      line_b[c] = mid;
      line_a[c] = bot;

      if (c == 0) begin
         // right edge of the previous row sees zero padding
         shift_column('0, '0, '0);
         if (r >= 2) begin
            res = next_median_pixel(w, h);
            got = 1'b1;
         end
         for (k = 0; k < 6; k++) win[k] = '0;
         win[6] = top;
         win[7] = mid;
         win[8] = bot;
      end else begin
         shift_column(top, mid, bot);
         if (r >= 1) begin
            res = next_median_pixel(w, h);
            got = 1'b1;
         end
      end

      c++;
      if (c >= w) begin
         c = 0;
         r++;
      end
      in_col = c;
      in_row = r;
      return got;
   endfunction

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   function automatic req_type pixel_req(logic [7:0] rr, logic [7:0] gg, logic [7:0] bb);
      req_type rq;
      rq.action   = ACTION_PIXEL;
      rq.red_in   = rr;
      rq.green_in = gg;
      rq.blue_in  = bb;
      return rq;
   endfunction

   // channels carry noise; a flush ignores them
   function automatic req_type flush_req();
      req_type rq;
      rq.action = ACTION_FLUSH;
      {rq.red_in, rq.green_in, rq.blue_in} = 24'($urandom);
      return rq;
   endfunction

   // a quarter of the pixels use only 0 and 255 so medians see many ties
   function automatic req_type rand_pixel();
      req_type rq;
      rq.action = ACTION_PIXEL;
      if ($urandom_range(0, 3) == 0) begin
         rq.red_in   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         rq.green_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         rq.blue_in  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
         {rq.red_in, rq.green_in, rq.blue_in} = 24'($urandom);
      end
      return rq;
   endfunction

   // send one request, predict at acceptance, then maybe leave a gap
   task automatic push_request(input req_type rq);
      rsp_type res;
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (median_step(rq, res)) expected_medians.push_back(res);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // stop requests, wait for every expected pixel, then let the pipe run empty
   task automatic settle();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_medians.size() != 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_medians.size() != 0) begin
         report_mismatch($sformatf("%0d results never came", expected_medians.size()));
         expected_medians.delete();
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_W-1:0] val);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) cfg_width = val[FW_W-1:0];
      else cfg_height = val[FH_W-1:0];
      clear_positions();
   endtask

   // full frame of random pixels plus the flushes that drain it
   task automatic run_frame(int unsigned w, int unsigned h);
      int unsigned k;
      for (k = 0; k < w * h; k++) push_request(rand_pixel());
      for (k = 0; k <= w; k++) push_request(flush_req());
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t tb: mismatch: %s", $time, what);
   endtask

   // ------------------------------------------------------------------
   // output side: random stall bursts and checking
   // ------------------------------------------------------------------

   initial begin : rsp_backpressure
      forever begin
         @(posedge clock);
         if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_medians.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = expected_medians.pop_front();
            if (rsp_data.red_out !== want.red_out)
               report_mismatch($sformatf("red got %0d want %0d",
                                         rsp_data.red_out, want.red_out));
            if (rsp_data.green_out !== want.green_out)
               report_mismatch($sformatf("green got %0d want %0d",
                                         rsp_data.green_out, want.green_out));
            if (rsp_data.blue_out !== want.blue_out)
               report_mismatch($sformatf("blue got %0d want %0d",
                                         rsp_data.blue_out, want.blue_out));
            if (rsp_data.frame_last !== want.frame_last)
               report_mismatch($sformatf("frame_last got %b want %b",
                                         rsp_data.frame_last, want.frame_last));
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // power-on geometry 640x480: one row and a bit give the first pixels
   task automatic test_reset_geometry();
      int unsigned k;
      for (k = 0; k < 643; k++) push_request(rand_pixel());
   endtask

   // clamped sizes, ignored requests, saturated channels
   task automatic test_corners();
      int unsigned k;
      write_csr(CSR_FRAME_WIDTH, CSR_W'(0));    // acts as 2
      write_csr(CSR_FRAME_HEIGHT, CSR_W'(1));   // acts as 2
      push_request(flush_req());                // flush before the last pixel: dropped
      push_request(pixel_req(8'hFF, 8'h00, 8'hFF));
      push_request(pixel_req(8'h00, 8'hFF, 8'h80));
      push_request(pixel_req(8'hFF, 8'hFF, 8'h01));
      push_request(pixel_req(8'h00, 8'h00, 8'hFE));
      push_request(pixel_req(8'h7F, 8'h7F, 8'h7F));   // pixel while draining: dropped
      repeat (3) push_request(flush_req());
      push_request(flush_req());                // belongs to the next frame: dropped

      write_csr(CSR_FRAME_WIDTH, CSR_W'(3));
      write_csr(CSR_FRAME_HEIGHT, CSR_W'(3));
      for (k = 0; k < 9; k++)
         push_request(pixel_req((k % 2 == 0) ? 8'hFF : 8'h00, 8'(k * 31), 8'(255 - k * 17)));
      repeat (4) push_request(flush_req());
   endtask

   // a register write mid-frame drops it; frames also run back to back
   task automatic test_abandon();
      int unsigned k;
      write_csr(CSR_FRAME_WIDTH, CSR_W'(5));
      write_csr(CSR_FRAME_HEIGHT, CSR_W'(4));
      for (k = 0; k < 13; k++) push_request(rand_pixel());
      write_csr(CSR_FRAME_HEIGHT, CSR_W'(4));
      run_frame(5, 4);
      run_frame(5, 4);
   endtask

   // height field all ones at the narrowest width, cut after a dozen rows
   task automatic test_tall_frame();
      int unsigned k;
      idle_pct = 5;
      write_csr(CSR_FRAME_WIDTH, CSR_W'(2));
      write_csr(CSR_FRAME_HEIGHT, 13'h1FFF);
      for (k = 0; k < 24; k++) push_request(rand_pixel());
      push_request(flush_req());                // frame still open: dropped
      write_csr(CSR_FRAME_HEIGHT, 13'h1FFF);
   endtask

   // mostly clean frames of random size, with dropped requests and cut frames mixed in
   task automatic test_random_frames();
      int unsigned sent, w, h, fw, fh, cut, k;
      bit fresh, cut_short;
      sent  = 0;
      fresh = 1'b1;
      w = 2;
      h = 2;
      while (sent < 60) begin
         case ($urandom_range(0, 3))
            0: idle_pct = 0;
            1: idle_pct = 3;
            2: idle_pct = 10;
            default: idle_pct = 30;
         endcase
         if (fresh || $urandom_range(0, 2) != 0) begin
            w  = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 16) : $urandom_range(2, 9);
            h  = $urandom_range(2, 6);
            fw = w;
            fh = h;
            if ($urandom_range(0, 9) == 0) begin
               fw = $urandom_range(0, 1);
               w  = 2;
            end
            if ($urandom_range(0, 9) == 0) begin
               fh = $urandom_range(0, 1);
               h  = 2;
            end
            write_csr(CSR_FRAME_WIDTH, CSR_W'(fw));
            write_csr(CSR_FRAME_HEIGHT, CSR_W'(fh));
            fresh = 1'b0;
         end

         cut_short = ($urandom_range(0, 9) == 0);
         cut = cut_short ? $urandom_range(1, w * h - 1) : w * h;
         for (k = 0; k < cut; k++) begin
            if ($urandom_range(0, 19) == 0) push_request(flush_req());
            push_request(rand_pixel());
            sent++;
         end
         if (cut_short) begin
            write_csr(CSR_FRAME_HEIGHT, CSR_W'(fh));
            continue;
         end
         for (k = 0; k <= w; k++) begin
            if ($urandom_range(0, 19) == 0) push_request(rand_pixel());
            push_request(flush_req());
            sent++;
         end
      end
   endtask

   // no gaps and no stalls at all
   task automatic test_steady_stream();
      idle_pct = 0;
      write_csr(CSR_FRAME_WIDTH, CSR_W'(8));
      write_csr(CSR_FRAME_HEIGHT, CSR_W'(3));
      run_frame(8, 3);
      run_frame(8, 3);
      write_csr(CSR_FRAME_WIDTH, CSR_W'(7));
      write_csr(CSR_FRAME_HEIGHT, CSR_W'(3));
      run_frame(7, 3);
   endtask

   initial begin : main_seq
      int k;
      cfg_width  = FRAME_WIDTH_RST;
      cfg_height = FRAME_HEIGHT_RST;
      for (k = 0; k < MAX_W; k++) begin
         line_a[k] = '0;
         line_b[k] = '0;
      end
      for (k = 0; k < 9; k++) win[k] = '0;
      clear_positions();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_geometry();
      test_corners();
      test_abandon();
      test_tall_frame();
      test_random_frames();
      test_steady_stream();
      settle();

      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // hang guard
   initial begin : watchdog
      #15_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule

### rgb_median_filter_3x3_unit.f
+incdir+rtl
rtl/rmf_pkg.sv
rtl/rmf_median.sv
rtl/rmf_line_mem.sv
rtl/rgb_median_filter_3x3_unit.sv
rtl/rmf_checker.sv
verif/tb.sv
